// ===== rtl/core/fm_audio_modulator_core_assert.svh =====
// assertion macros for the fm modulator core
`ifndef FM_AUDIO_MODULATOR_CORE_ASSERT_SVH
`define FM_AUDIO_MODULATOR_CORE_ASSERT_SVH
`ifndef SYNTH
`define FMAM_ASSERT(lbl, clk_s, rst_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) \
    else $error("fmam property violated");
`define FMAM_ASSERT_NEVER(lbl, clk_s, rst_s, cond) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) !(cond)) \
    else $error("fmam forbidden condition seen");
`else
`define FMAM_ASSERT(lbl, clk_s, rst_s, prop)
`define FMAM_ASSERT_NEVER(lbl, clk_s, rst_s, cond)
`endif
`endif

// ===== rtl/core/fmam_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package fmam_pkg;

  localparam int SAMPLE_W = 16;
  localparam int SINE_W   = 15;
  localparam int MUL_A_W  = 17;
  localparam int MUL_B_W  = 32;
  localparam int PROD_W   = MUL_A_W + MUL_B_W;

  // pi/2 and one in q30, used to build the quarter-wave table
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint ONE_Q30     = 64'sd1073741824;

  typedef struct packed {
    logic                      load;
    logic signed [MUL_A_W-1:0] a;
    logic signed [MUL_B_W-1:0] b;
  } mul_req_t;

endpackage
`default_nettype wire

// ===== rtl/core/fmam_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none
module fmam_mul (
  input  logic                                 clk,
  input  fmam_pkg::mul_req_t                   req,
  output logic signed [fmam_pkg::PROD_W-1:0]   prod
);
  import fmam_pkg::*;

  // shared signed multiplier, product held until the next load
  always_ff @(posedge clk) begin
    if (req.load) begin
      prod <= req.a * req.b;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/fmam_sine_rom.sv =====
`timescale 1ns / 1ps
`default_nettype none
module fmam_sine_rom #(
  parameter int ENTRIES = 1024,
  parameter int ADDR_W  = 10
) (
  input  logic                          clk,
  input  logic [ADDR_W-1:0]             addr,
  output logic [fmam_pkg::SINE_W-1:0]   rd_data
);
  import fmam_pkg::*;

  typedef logic [SINE_W-1:0] sine_tbl_t [ENTRIES];

  // round(32767 * sin(k * pi/2 / ENTRIES)) by a q30 taylor series
  function automatic sine_tbl_t build_sine_tbl();
    sine_tbl_t tbl;
    longint    x;
    longint    x2;
    longint    term;
    longint    sum;
    longint    v;
    for (int k = 0; k < ENTRIES; k++) begin
      x    = (longint'(k) * HALF_PI_Q30) / ENTRIES;
      x2   = (x * x) >>> 30;
      term = x;
      sum  = x;
      for (int n = 1; n <= 7; n++) begin
        term = (term * x2) >>> 30;
        case (n)
          1: term = term / 6;
          2: term = term / 20;
          3: term = term / 42;
          4: term = term / 72;
          5: term = term / 110;
          6: term = term / 156;
          7: term = term / 210;
          default: term = 0;
        endcase
        if ((n & 1) == 1) sum = sum - term;
        else sum = sum + term;
      end
      if (sum < 0) sum = 0;
      v = (sum * 32767 + ONE_Q30 / 2) >>> 30;
      if (v > 32767) v = 32767;
      tbl[k] = SINE_W'(v);
    end
    return tbl;
  endfunction

  localparam sine_tbl_t SINE_TBL = build_sine_tbl();

  always_ff @(posedge clk) begin
    rd_data <= SINE_TBL[addr];
  end

endmodule
`default_nettype wire

// ===== rtl/core/fm_audio_modulator_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// fm modulator core: each audio item advances a phase accumulator by carrier_step plus
// the sample scaled by deviation_step, looks the new phase up in a quarter-wave sine
// rom and returns the sine scaled by amplitude, saturated to +-32767. the accept cycle
// starts the deviation product, then the phase add, the registered rom read, the gain
// product and the output stage follow, and the next item is taken only once the output
// register has loaded, so one item is in flight at a time. one multiplier is shared by
// both products. in_stall stays high until the result is loaded, longer while an earlier
// result is held by out_stall. the rom is a fixed table with no fill after reset.
// registers sit at byte addresses 0, 4 and 8 of the apb port.
module fm_audio_modulator_core #(
  parameter int SINE_ENTRIES = 1024,
  parameter int PHASE_BITS   = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [3:0]                            paddr,
  input  logic [31:0]                           pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [fmam_pkg::SAMPLE_W-1:0]  audio_in,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [fmam_pkg::SAMPLE_W-1:0]  audio_out
);
  import fmam_pkg::*;

  localparam logic [1:0] REG_CARRIER = 2'd0;
  localparam logic [1:0] REG_DEV     = 2'd1;
  localparam logic [1:0] REG_AMP     = 2'd2;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PHASE = 3'd1;
  localparam logic [2:0] S_ADDR  = 3'd2;
  localparam logic [2:0] S_MUL2  = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  localparam int ADDR_W = $clog2(SINE_ENTRIES);
  localparam int IDX_W  = $clog2(SINE_ENTRIES + 1);
  localparam int QUAD   = 4 * SINE_ENTRIES;
  localparam int POS_W  = $clog2(QUAD);
  localparam int PP_W   = 16 + POS_W;
  localparam int DEV_W  = PROD_W - 15;
  localparam int SUM_W  = (PHASE_BITS > DEV_W) ? PHASE_BITS : DEV_W;

  localparam logic [POS_W-1:0] Q1_START = POS_W'(SINE_ENTRIES);
  localparam logic [POS_W-1:0] Q2_START = POS_W'(2 * SINE_ENTRIES);
  localparam logic [POS_W-1:0] Q3_START = POS_W'(3 * SINE_ENTRIES);

  logic [31:0]           carrier_step;
  logic [30:0]           deviation_step;
  logic [15:0]           amplitude;
  logic [PHASE_BITS-1:0] phase_acc;
  logic [2:0]            state;
  logic [2:0]            state_next;

  logic                       accept;
  logic                       out_load;
  logic                       cfg_write;
  mul_req_t                   mul_req;
  logic signed [PROD_W-1:0]   prod;
  logic signed [DEV_W-1:0]    dev;
  logic signed [SUM_W-1:0]    dev_w;
  logic [SUM_W-1:0]           phase_sum;
  logic [PP_W-1:0]            pos_prod;
  logic [POS_W-1:0]           pos;
  logic [POS_W-1:0]           diff;
  logic [1:0]                 quad;
  logic [IDX_W-1:0]           idx;
  logic [IDX_W-1:0]           rom_addr;
  logic [SINE_W-1:0]          rom_q;
  logic                       neg_q;
  logic                       full_q;
  logic [SINE_W-1:0]          mag;
  logic signed [MUL_A_W-1:0]  sine_s;
  logic signed [DEV_W-1:0]    y;
  logic signed [SAMPLE_W-1:0] y_sat;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_load  = (state == S_OUT) && (!out_valid || !out_stall);

  always_comb begin
    case (paddr[3:2])
      REG_CARRIER: prdata = carrier_step;
      REG_DEV:     prdata = {1'b0, deviation_step};
      REG_AMP:     prdata = {16'h0000, amplitude};
      default:     prdata = 32'h0000_0000;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      carrier_step   <= 32'd292156718;
      deviation_step <= 31'd0;
      amplitude      <= 16'd32768;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_CARRIER: carrier_step   <= pwdata;
        REG_DEV:     deviation_step <= pwdata[30:0];
        REG_AMP:     amplitude      <= pwdata[15:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (accept) state_next = S_PHASE;
      S_PHASE: state_next = S_ADDR;
      S_ADDR:  state_next = S_MUL2;
      S_MUL2:  state_next = S_OUT;
      S_OUT:   if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // multiplier operands: deviation product at accept, gain product later
  always_comb begin
    mul_req.load = 1'b0;
    mul_req.a    = {audio_in[SAMPLE_W-1], audio_in};
    mul_req.b    = {1'b0, deviation_step};
    if (state == S_IDLE) begin
      mul_req.load = accept;
    end else if (state == S_MUL2) begin
      mul_req.load = 1'b1;
      mul_req.a    = sine_s;
      mul_req.b    = {16'h0000, amplitude};
    end
  end

  fmam_mul u_mul (
    .clk  (clk),
    .req  (mul_req),
    .prod (prod)
  );

  // arithmetic shift gives the floor of the division by 2^15
  assign dev       = $signed(prod[PROD_W-1:15]);
  assign dev_w     = SUM_W'(dev);
  assign phase_sum = SUM_W'(phase_acc) + SUM_W'(carrier_step) + dev_w;

  always_ff @(posedge clk) begin
    if (rst) phase_acc <= '0;
    else if (state == S_PHASE) phase_acc <= phase_sum[PHASE_BITS-1:0];
  end

  // phase to quadrant and table index, mirrored in odd quadrants
  always_comb begin
    pos_prod = PP_W'(phase_acc[PHASE_BITS-1 -: 16]) * PP_W'(QUAD);
    pos      = pos_prod[16 +: POS_W];
    if (pos >= Q3_START) begin
      quad = 2'd3;
      diff = pos - Q3_START;
    end else if (pos >= Q2_START) begin
      quad = 2'd2;
      diff = pos - Q2_START;
    end else if (pos >= Q1_START) begin
      quad = 2'd1;
      diff = pos - Q1_START;
    end else begin
      quad = 2'd0;
      diff = pos;
    end
    idx      = diff[IDX_W-1:0];
    rom_addr = quad[0] ? (IDX_W'(SINE_ENTRIES) - idx) : idx;
  end

  fmam_sine_rom #(
    .ENTRIES (SINE_ENTRIES),
    .ADDR_W  (ADDR_W)
  ) u_rom (
    .clk     (clk),
    .addr    (rom_addr[ADDR_W-1:0]),
    .rd_data (rom_q)
  );

  // flags line up with the registered rom data
  always_ff @(posedge clk) begin
    neg_q  <= quad[1];
    full_q <= (rom_addr == IDX_W'(SINE_ENTRIES));
  end

  assign mag    = full_q ? {SINE_W{1'b1}} : rom_q;
  assign sine_s = neg_q ? -$signed({2'b00, mag}) : $signed({2'b00, mag});

  assign y = $signed(prod[PROD_W-1:15]);

  always_comb begin
    if (y > DEV_W'(32767)) y_sat = 16'sd32767;
    else if (y < -DEV_W'(32767)) y_sat = -16'sd32767;
    else y_sat = y[SAMPLE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (out_load) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (out_load) audio_out <= y_sat;
  end

`include "fm_audio_modulator_core_assert.svh"

  `FMAM_ASSERT(a_accept_starts_phase, clk, rst, accept |=> (state == S_PHASE))
  `FMAM_ASSERT(a_out_rise_from_out, clk, rst, $rose(out_valid) |-> ($past(state) == S_OUT))
  `FMAM_ASSERT(a_out_waits_blocked, clk, rst, ((state == S_OUT) && out_valid && out_stall) |=> (state == S_OUT))
  `FMAM_ASSERT_NEVER(a_out_saturated, clk, rst, out_valid && (audio_out == -16'sd32768))

endmodule
`default_nettype wire
